// ===== hw/rtl/mtmt_pkg.sv =====
// Package for the multicast tree member table: codes, payload types and constants.
// No dependencies; every other file of the block but mtmt_cell imports it.
package mtmt_pkg;

    typedef logic [31:0] addr_t;
    typedef logic [9:0]  cost_t;

    // One table entry: address with its cost (link and child tables).
    typedef struct packed {
        cost_t cost;
        addr_t addr;
    } entry_t;

    // Control of one ring of cells for one step.
    typedef struct packed {
        logic shift;
        logic wr_en;
    } ring_ctl_t;

    // Input actions.
    localparam logic [2:0] ACT_LOAD   = 3'd0;
    localparam logic [2:0] ACT_TJOIN  = 3'd1;
    localparam logic [2:0] ACT_RJOIN  = 3'd2;
    localparam logic [2:0] ACT_CJOIN  = 3'd3;
    localparam logic [2:0] ACT_SEG    = 3'd4;
    localparam logic [2:0] ACT_TPRUNE = 3'd5;
    localparam logic [2:0] ACT_CPRUNE = 3'd6;
    localparam logic [2:0] ACT_DATA   = 3'd7;

    // Result kinds.
    localparam logic [2:0] KIND_DONE         = 3'd0;
    localparam logic [2:0] KIND_JOIN_ROOT    = 3'd1;
    localparam logic [2:0] KIND_SEGMENT      = 3'd2;
    localparam logic [2:0] KIND_SEND_VECTOR  = 3'd3;
    localparam logic [2:0] KIND_JOIN_PARENT  = 3'd4;
    localparam logic [2:0] KIND_PRUNE_ROOT   = 3'd5;
    localparam logic [2:0] KIND_PRUNE_PARENT = 3'd6;
    localparam logic [2:0] KIND_FORWARD      = 3'd7;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_OWN_ADDR  = 1'b0;
    localparam logic CFG_ROOT_ADDR = 1'b1;

    localparam cost_t UNKNOWN_COST = 10'd999;
    localparam cost_t COST_MAX     = 10'd1023;

endpackage

// ===== hw/rtl/mtmt_cell.sv =====
// One storage cell of a member ring: holds one entry and takes its neighbor's on a shift.
// Uses no package items.
module mtmt_cell #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         shift,
    input  logic [W-1:0] din,
    output logic [W-1:0] q
);

    logic [W-1:0] q_reg;

    // Load from the neighbor on every shift step.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= din;
        end
    end

    assign q = q_reg;

endmodule

// ===== hw/rtl/mtmt_ring.sv =====
// A ring of mtmt_cell instances: entries rotate one place per shift, head is cell zero.
// Depends on mtmt_pkg and mtmt_cell.
module mtmt_ring
    import mtmt_pkg::*;
#(
    parameter int W = 32,
    parameter int N = 16
) (
    input  logic         clk,
    input  ring_ctl_t    ctl,
    input  logic [W-1:0] wr_data,
    output logic [W-1:0] head
);

    logic [W-1:0] q [N];
    logic [W-1:0] feed;

    // The head goes back in at the tail unless this step replaces it.
    assign feed = ctl.wr_en ? wr_data : q[0];
    assign head = q[0];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        mtmt_cell #(.W(W)) u_cell (
            .clk   (clk),
            .shift (ctl.shift),
            .din   ((i == N - 1) ? feed : q[(i + 1) % N]),
            .q     (q[i])
        );
    end

endmodule

// ===== hw/rtl/multicast_tree_member_table_unit.sv =====
// Multicast tree member table, top level: sequencer, node state and three cell rings.
// Depends on mtmt_pkg, mtmt_ring and mtmt_cell.
//
// The link, terminal and child tables each sit in a ring of MAX_MEMBERS cells
// that rotates one entry per cycle past a single compare point, save that ring
// walks hold while the output is stalled. Every item takes an idle step, a
// search pass over all MAX_MEMBERS cells, a decision step and a write pass over
// all MAX_MEMBERS cells before its first result. Data items with recipients walk
// the terminal ring and then the child ring, joins at the root with children walk
// the child ring twice, and every emission step waits while the output is
// stalled. One item is worked on at a time; the next is accepted while the last
// result still sits in the output register.
module multicast_tree_member_table_unit
    import mtmt_pkg::*;
#(
    parameter int MAX_MEMBERS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // Input item.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // addr[31:0], value[41:32], zero pad
    input  logic [2:0]   s_tuser,   // action[2:0]
    // Result item.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // dest_addr, seg_addr, seg_cost, status,
                                    // sequence_res, zero pad (lowest first)
    output logic [2:0]   m_tuser,   // kind[2:0]
    output logic         m_tlast,
    // Configuration writes.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int IW = $clog2(MAX_MEMBERS);
    localparam int CW = $clog2(MAX_MEMBERS + 1);
    localparam int RW = $clog2(2 * MAX_MEMBERS + 2);
    localparam int EW = $bits(entry_t);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_UPDATE = 4'd3;
    localparam logic [3:0] S_ONE    = 4'd4;
    localparam logic [3:0] S_TWO    = 4'd5;
    localparam logic [3:0] S_RT     = 4'd6;
    localparam logic [3:0] S_RC1    = 4'd7;
    localparam logic [3:0] S_RC2    = 4'd8;

    localparam logic [IW-1:0] POS_LAST = IW'(MAX_MEMBERS - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_MEMBERS);

    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [2:0]    act_reg, act_next;
    addr_t         addr_reg, addr_next;
    cost_t         val_reg, val_next;
    addr_t         own_reg, own_next, root_reg, root_next;
    logic [CW-1:0] lcnt_reg, lcnt_next, tcnt_reg, tcnt_next, ccnt_reg, ccnt_next;
    cost_t         path_reg, path_next;
    addr_t         parent_reg, parent_next;
    logic          seen_reg, seen_next;
    logic [31:0]   seq_reg, seq_next;
    // Search results.
    logic          lk_hit_reg, lk_hit_next, tm_hit_reg, tm_hit_next;
    logic          ch_hit_reg, ch_hit_next;
    cost_t         lk_cost_reg, lk_cost_next;
    logic [IW-1:0] tm_idx_reg, tm_idx_next, ch_idx_reg, ch_idx_next;
    addr_t         tm_last_reg, tm_last_next;
    entry_t        ch_last_reg, ch_last_next;
    // Plan of the current item.
    logic [1:0]    st_reg, st_next;
    logic [2:0]    one_kind_reg, one_kind_next, two_kind_reg, two_kind_next;
    addr_t         one_dest_reg, one_dest_next, two_dest_reg, two_dest_next;
    addr_t         one_seg_reg, one_seg_next;
    logic          go_one_reg, go_one_next, go_two_reg, go_two_next;
    logic          go_rc1_reg, go_rc1_next, go_rc2_reg, go_rc2_next;
    logic [RW-1:0] remain_reg, remain_next;
    // Pending table writes.
    logic          l_we_reg, l_we_next, t_we_reg, t_we_next, c_we_reg, c_we_next;
    logic [IW-1:0] l_wpos_reg, l_wpos_next, t_wpos_reg, t_wpos_next;
    logic [IW-1:0] c_wpos_reg, c_wpos_next;
    entry_t        l_wdata_reg, l_wdata_next, c_wdata_reg, c_wdata_next;
    addr_t         t_wdata_reg, t_wdata_next;
    // Output register.
    logic          out_valid_reg, out_valid_next, out_last_reg, out_last_next;
    logic [2:0]    out_kind_reg, out_kind_next;
    addr_t         out_dest_reg, out_dest_next, out_seg_reg, out_seg_next;
    cost_t         out_cost_reg, out_cost_next;
    logic [1:0]    out_st_reg, out_st_next;
    logic [31:0]   out_seq_reg, out_seq_next;

    ring_ctl_t     l_ctl, t_ctl, c_ctl;
    logic [EW-1:0] l_head_raw, c_head_raw;
    logic [31:0]   t_head;
    entry_t        l_head, c_head;
    logic          shift, free;
    logic [CW-1:0] pos_ext;

    assign l_head = entry_t'(l_head_raw);
    assign c_head = entry_t'(c_head_raw);
    assign free    = !out_valid_reg || m_tready;
    assign pos_ext = CW'(pos_reg);

    // Rings rotate in every search and write step, and in ring walks when the output register is free.
    assign shift = (state_reg == S_SCAN) || (state_reg == S_UPDATE) ||
                   (((state_reg == S_RT) || (state_reg == S_RC1) || (state_reg == S_RC2))
                    && free);
    assign l_ctl = '{shift: shift,
                     wr_en: (state_reg == S_UPDATE) && l_we_reg && (pos_reg == l_wpos_reg)};
    assign t_ctl = '{shift: shift,
                     wr_en: (state_reg == S_UPDATE) && t_we_reg && (pos_reg == t_wpos_reg)};
    assign c_ctl = '{shift: shift,
                     wr_en: (state_reg == S_UPDATE) && c_we_reg && (pos_reg == c_wpos_reg)};

    mtmt_ring #(.W(EW), .N(MAX_MEMBERS)) u_link_ring (
        .clk(clk), .ctl(l_ctl), .wr_data(l_wdata_reg), .head(l_head_raw)
    );
    mtmt_ring #(.W(32), .N(MAX_MEMBERS)) u_term_ring (
        .clk(clk), .ctl(t_ctl), .wr_data(t_wdata_reg), .head(t_head)
    );
    mtmt_ring #(.W(EW), .N(MAX_MEMBERS)) u_child_ring (
        .clk(clk), .ctl(c_ctl), .wr_data(c_wdata_reg), .head(c_head_raw)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_kind_reg;
    assign m_tdata   = {4'd0, out_seq_reg, out_st_reg, out_cost_reg, out_seg_reg, out_dest_reg};

    // Sequencer, node state and result generation.
    always_comb
    begin
        logic          is_root, emit;
        addr_t         cur_par;
        logic [10:0]   sum;
        cost_t         score, cur_cost;
        logic [CW-1:0] nt, nc;
        logic [2:0]    e_kind;
        addr_t         e_dest, e_seg;
        cost_t         e_cost;

        state_next = state_reg;  pos_next = pos_reg;
        act_next = act_reg;  addr_next = addr_reg;  val_next = val_reg;
        own_next = own_reg;  root_next = root_reg;
        lcnt_next = lcnt_reg;  tcnt_next = tcnt_reg;  ccnt_next = ccnt_reg;
        path_next = path_reg;  parent_next = parent_reg;  seen_next = seen_reg;
        seq_next = seq_reg;
        lk_hit_next = lk_hit_reg;  tm_hit_next = tm_hit_reg;  ch_hit_next = ch_hit_reg;
        lk_cost_next = lk_cost_reg;  tm_idx_next = tm_idx_reg;  ch_idx_next = ch_idx_reg;
        tm_last_next = tm_last_reg;  ch_last_next = ch_last_reg;
        st_next = st_reg;  one_kind_next = one_kind_reg;  two_kind_next = two_kind_reg;
        one_dest_next = one_dest_reg;  two_dest_next = two_dest_reg;
        one_seg_next = one_seg_reg;
        go_one_next = go_one_reg;  go_two_next = go_two_reg;
        go_rc1_next = go_rc1_reg;  go_rc2_next = go_rc2_reg;
        remain_next = remain_reg;
        l_we_next = l_we_reg;  t_we_next = t_we_reg;  c_we_next = c_we_reg;
        l_wpos_next = l_wpos_reg;  t_wpos_next = t_wpos_reg;  c_wpos_next = c_wpos_reg;
        l_wdata_next = l_wdata_reg;  t_wdata_next = t_wdata_reg;
        c_wdata_next = c_wdata_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_last_next = out_last_reg;  out_kind_next = out_kind_reg;
        out_dest_next = out_dest_reg;  out_seg_next = out_seg_reg;
        out_cost_next = out_cost_reg;  out_st_next = out_st_reg;
        out_seq_next = out_seq_reg;

        is_root  = (own_reg == root_reg);
        cur_par  = (parent_reg == '0) ? root_reg : parent_reg;
        cur_cost = is_root ? '0 : path_reg;
        sum      = {1'b0, val_reg} + {1'b0, (lk_hit_reg ? lk_cost_reg : UNKNOWN_COST)};
        score    = sum[10] ? COST_MAX : sum[9:0];
        nt       = tcnt_reg;
        nc       = ccnt_reg;
        emit     = 1'b0;
        e_kind   = KIND_DONE;
        e_dest   = '0;
        e_seg    = '0;
        e_cost   = '0;

        // Configuration writes.
        if (cfg_valid)
        begin
            if (cfg_index == CFG_OWN_ADDR)
            begin
                own_next = cfg_data;
            end
            else
            begin
                root_next = cfg_data;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next    = s_tuser;
                    addr_next   = s_tdata[31:0];
                    val_next    = s_tdata[41:32];
                    lk_hit_next = 1'b0;
                    tm_hit_next = 1'b0;
                    ch_hit_next = 1'b0;
                    pos_next    = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Search pass: one entry of each table per cycle.
                if ((pos_ext < lcnt_reg) && (l_head.addr == addr_reg) && !lk_hit_reg)
                begin
                    lk_hit_next  = 1'b1;
                    lk_cost_next = l_head.cost;
                end
                if ((pos_ext < tcnt_reg) && (t_head == addr_reg))
                begin
                    tm_hit_next = 1'b1;
                    tm_idx_next = pos_reg;
                end
                if (pos_ext + CW'(1) == tcnt_reg)
                begin
                    tm_last_next = t_head;
                end
                if ((pos_ext < ccnt_reg) && (c_head.addr == addr_reg))
                begin
                    ch_hit_next = 1'b1;
                    ch_idx_next = pos_reg;
                end
                if (pos_ext + CW'(1) == ccnt_reg)
                begin
                    ch_last_next = c_head;
                end
                pos_next = pos_reg + IW'(1);
                if (pos_reg == POS_LAST)
                begin
                    pos_next   = '0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                st_next = ST_OK;
                go_one_next = 1'b1;
                go_two_next = 1'b0;
                go_rc1_next = 1'b0;
                go_rc2_next = 1'b0;
                one_kind_next = KIND_DONE;
                one_dest_next = '0;
                one_seg_next = '0;
                remain_next = RW'(1);
                l_we_next = 1'b0;
                t_we_next = 1'b0;
                c_we_next = 1'b0;
                unique case (act_reg)
                    ACT_LOAD:
                    begin
                        if (lcnt_reg == CNT_FULL)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            l_we_next    = 1'b1;
                            l_wpos_next  = IW'(lcnt_reg);
                            l_wdata_next = '{cost: val_reg, addr: addr_reg};
                            lcnt_next    = lcnt_reg + CW'(1);
                            if ((addr_reg == root_reg) && !seen_reg)
                            begin
                                path_next = val_reg;
                                seen_next = 1'b1;
                            end
                        end
                    end
                    ACT_TJOIN:
                    begin
                        if (tm_hit_reg)
                        begin
                            st_next = ST_PRESENT;
                        end
                        else if (tcnt_reg == CNT_FULL)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            t_we_next    = 1'b1;
                            t_wpos_next  = IW'(tcnt_reg);
                            t_wdata_next = addr_reg;
                            tcnt_next    = tcnt_reg + CW'(1);
                        end
                        one_kind_next = KIND_JOIN_ROOT;
                        one_dest_next = root_reg;
                    end
                    ACT_RJOIN:
                    begin
                        if (!is_root)
                        begin
                            st_next = ST_IGNORED;
                        end
                        else
                        begin
                            if (ch_hit_reg)
                            begin
                                st_next = ST_PRESENT;
                            end
                            else if (ccnt_reg == CNT_FULL)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                c_we_next    = 1'b1;
                                c_wpos_next  = IW'(ccnt_reg);
                                c_wdata_next = '{cost: (lk_hit_reg ? lk_cost_reg : cost_t'(1)),
                                                 addr: addr_reg};
                                nc           = ccnt_reg + CW'(1);
                                ccnt_next    = nc;
                            end
                            one_kind_next = KIND_SEGMENT;
                            one_seg_next  = own_reg;
                            go_rc1_next   = (nc != '0);
                            go_rc2_next   = (nc != '0);
                            remain_next   = RW'({nc, 1'b0}) + RW'(1);
                        end
                    end
                    ACT_CJOIN:
                    begin
                        if (ch_hit_reg)
                        begin
                            st_next = ST_PRESENT;
                        end
                        else if (ccnt_reg == CNT_FULL)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            c_we_next    = 1'b1;
                            c_wpos_next  = IW'(ccnt_reg);
                            c_wdata_next = '{cost: cost_t'(1), addr: addr_reg};
                            ccnt_next    = ccnt_reg + CW'(1);
                        end
                    end
                    ACT_SEG:
                    begin
                        if ((addr_reg == own_reg) || (score > cur_cost) ||
                            ((score == cur_cost) && (cur_par != addr_reg)))
                        begin
                            st_next = ST_IGNORED;
                        end
                        else
                        begin
                            parent_next = addr_reg;
                            path_next   = score;
                            if (cur_par != addr_reg)
                            begin
                                one_kind_next = KIND_JOIN_PARENT;
                                one_dest_next = addr_reg;
                                two_kind_next = (cur_par == root_reg) ? KIND_PRUNE_ROOT
                                                                      : KIND_PRUNE_PARENT;
                                two_dest_next = cur_par;
                                go_two_next   = 1'b1;
                                remain_next   = RW'(2);
                            end
                        end
                    end
                    ACT_TPRUNE, ACT_CPRUNE:
                    begin
                        // Entries are unique, so at most one is replaced by the last one.
                        if (act_reg == ACT_TPRUNE)
                        begin
                            if (tm_hit_reg)
                            begin
                                t_we_next    = 1'b1;
                                t_wpos_next  = tm_idx_reg;
                                t_wdata_next = tm_last_reg;
                                nt           = tcnt_reg - CW'(1);
                                tcnt_next    = nt;
                            end
                            st_next = tm_hit_reg ? ST_OK : ST_IGNORED;
                        end
                        else
                        begin
                            if (ch_hit_reg)
                            begin
                                c_we_next    = 1'b1;
                                c_wpos_next  = ch_idx_reg;
                                c_wdata_next = ch_last_reg;
                                nc           = ccnt_reg - CW'(1);
                                ccnt_next    = nc;
                            end
                            st_next = ch_hit_reg ? ST_OK : ST_IGNORED;
                        end
                        if ((nt == '0) && (nc == '0) && !is_root)
                        begin
                            one_kind_next = (cur_par == root_reg) ? KIND_PRUNE_ROOT
                                                                  : KIND_PRUNE_PARENT;
                            one_dest_next = cur_par;
                        end
                    end
                    ACT_DATA:
                    begin
                        seq_next    = seq_reg + 32'd1;
                        remain_next = RW'(tcnt_reg) + RW'(ccnt_reg) - RW'(ch_hit_reg);
                        if ((tcnt_reg != '0) || (ccnt_reg != '0 && !(ccnt_reg == CW'(1)
                                                                     && ch_hit_reg)))
                        begin
                            go_one_next = 1'b0;
                            go_rc1_next = 1'b1;
                        end
                        else
                        begin
                            remain_next = RW'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                pos_next = pos_reg + IW'(1);
                if (pos_reg == POS_LAST)
                begin
                    pos_next   = '0;
                    state_next = go_one_reg ? S_ONE : S_RT;
                end
            end
            S_ONE:
            begin
                if (free)
                begin
                    emit   = 1'b1;
                    e_kind = one_kind_reg;
                    e_dest = one_dest_reg;
                    e_seg  = one_seg_reg;
                    state_next = go_two_reg ? S_TWO : (go_rc1_reg ? S_RC1 : S_IDLE);
                end
            end
            S_TWO:
            begin
                if (free)
                begin
                    emit   = 1'b1;
                    e_kind = two_kind_reg;
                    e_dest = two_dest_reg;
                    state_next = S_IDLE;
                end
            end
            S_RT, S_RC1, S_RC2:
            begin
                if (free)
                begin
                    if (state_reg == S_RT)
                    begin
                        emit   = (pos_ext < tcnt_reg);
                        e_kind = KIND_FORWARD;
                        e_dest = t_head;
                    end
                    else if (state_reg == S_RC2)
                    begin
                        emit   = (pos_ext < ccnt_reg);
                        e_kind = KIND_SEND_VECTOR;
                        e_dest = c_head.addr;
                    end
                    else if (act_reg == ACT_DATA)
                    begin
                        emit   = (pos_ext < ccnt_reg) && (c_head.addr != addr_reg);
                        e_kind = KIND_FORWARD;
                        e_dest = c_head.addr;
                    end
                    else
                    begin
                        emit   = (pos_ext < ccnt_reg);
                        e_kind = KIND_SEGMENT;
                        e_seg  = c_head.addr;
                        e_cost = c_head.cost;
                    end
                    pos_next = pos_reg + IW'(1);
                    if (pos_reg == POS_LAST)
                    begin
                        pos_next = '0;
                        if (state_reg == S_RT)
                        begin
                            state_next = S_RC1;
                        end
                        else if ((state_reg == S_RC1) && go_rc2_reg)
                        begin
                            state_next = S_RC2;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Load one result into the output register.
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = (remain_reg == RW'(1));
            remain_next    = remain_reg - RW'(1);
            out_kind_next  = e_kind;
            out_dest_next  = e_dest;
            out_seg_next   = e_seg;
            out_cost_next  = e_cost;
            out_st_next    = st_reg;
            out_seq_next   = (act_reg == ACT_DATA) ? seq_reg : 32'd0;
        end
    end

    // Control and node state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            own_reg       <= '0;
            root_reg      <= '0;
            lcnt_reg      <= '0;
            tcnt_reg      <= '0;
            ccnt_reg      <= '0;
            path_reg      <= UNKNOWN_COST;
            parent_reg    <= '0;
            seen_reg      <= 1'b0;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
            remain_reg    <= '0;
            go_one_reg    <= 1'b0;
            go_two_reg    <= 1'b0;
            go_rc1_reg    <= 1'b0;
            go_rc2_reg    <= 1'b0;
            l_we_reg      <= 1'b0;
            t_we_reg      <= 1'b0;
            c_we_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            own_reg       <= own_next;
            root_reg      <= root_next;
            lcnt_reg      <= lcnt_next;
            tcnt_reg      <= tcnt_next;
            ccnt_reg      <= ccnt_next;
            path_reg      <= path_next;
            parent_reg    <= parent_next;
            seen_reg      <= seen_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
            remain_reg    <= remain_next;
            go_one_reg    <= go_one_next;
            go_two_reg    <= go_two_next;
            go_rc1_reg    <= go_rc1_next;
            go_rc2_reg    <= go_rc2_next;
            l_we_reg      <= l_we_next;
            t_we_reg      <= t_we_next;
            c_we_reg      <= c_we_next;
        end
    end

    // Item, search and output payload.
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        addr_reg     <= addr_next;
        val_reg      <= val_next;
        lk_hit_reg   <= lk_hit_next;
        tm_hit_reg   <= tm_hit_next;
        ch_hit_reg   <= ch_hit_next;
        lk_cost_reg  <= lk_cost_next;
        tm_idx_reg   <= tm_idx_next;
        ch_idx_reg   <= ch_idx_next;
        tm_last_reg  <= tm_last_next;
        ch_last_reg  <= ch_last_next;
        st_reg       <= st_next;
        one_kind_reg <= one_kind_next;
        two_kind_reg <= two_kind_next;
        one_dest_reg <= one_dest_next;
        two_dest_reg <= two_dest_next;
        one_seg_reg  <= one_seg_next;
        l_wpos_reg   <= l_wpos_next;
        t_wpos_reg   <= t_wpos_next;
        c_wpos_reg   <= c_wpos_next;
        l_wdata_reg  <= l_wdata_next;
        t_wdata_reg  <= t_wdata_next;
        c_wdata_reg  <= c_wdata_next;
        out_last_reg <= out_last_next;
        out_kind_reg <= out_kind_next;
        out_dest_reg <= out_dest_next;
        out_seg_reg  <= out_seg_next;
        out_cost_reg <= out_cost_next;
        out_st_reg   <= out_st_next;
        out_seq_reg  <= out_seq_next;
    end

    // Table fill counts never pass the ring depth.
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (lcnt_reg <= CNT_FULL) && (tcnt_reg <= CNT_FULL) && (ccnt_reg <= CNT_FULL))
        else $error("table count beyond ring depth");

    // While the planned single results are being generated, some are still owed.
    a_remain: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ONE) || (state_reg == S_TWO)) |-> (remain_reg != '0))
        else $error("result expected with none remaining");

    // An accepted item starts a search pass.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_SCAN) && (pos_reg == '0))
        else $error("accepted item did not start a search");

    // Once the sequencer is idle, every result of the previous item has been issued.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (remain_reg == '0))
        else $error("results still owed while the sequencer is idle");

endmodule

// ===== bench/tb_multicast_tree_member_table_unit.sv =====
// Testbench for multicast_tree_member_table_unit: directed table plus random traffic,
// checked against an in-bench model of the member tables. Depends on mtmt_pkg and the RTL.
module tb_multicast_tree_member_table_unit;
    import mtmt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEMBERS = 16;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] dest;
        logic [31:0] seg_addr;
        logic [9:0]  seg_cost;
        logic [1:0]  status;
        logic [31:0] seq;
        logic        last;
    } tree_msg_t;

    typedef struct {
        logic [2:0]  action;
        logic [31:0] addr;
        logic [9:0]  value;
        logic        has_fixed;
        logic [2:0]  fixed_kind;
        logic [1:0]  fixed_status;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [2:0] m_tuser;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    multicast_tree_member_table_unit #(.MAX_MEMBERS(MEMBERS)) i_dut (.*);

    always #10 clk = ~clk;

    // Model state of the node.
    logic [31:0] m_own, m_root;
    logic [31:0] lk_addr [MEMBERS];
    logic [9:0]  lk_cost [MEMBERS];
    int          lk_cnt;
    logic [31:0] tm_addr [MEMBERS];
    int          tm_cnt;
    logic [31:0] ch_addr [MEMBERS];
    logic [9:0]  ch_cost [MEMBERS];
    int          ch_cnt;
    logic [9:0]  m_path;
    logic [31:0] m_parent;
    logic        m_root_seen;
    logic [31:0] m_dseq;

    tree_msg_t pending_msgs[$];
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_reroutes = 0;

    function automatic logic [31:0] parent_now();
        return (m_parent == 0) ? m_root : m_parent;
    endfunction

    function automatic void push_msg(logic [2:0] k, logic [31:0] d, logic [31:0] sa,
                                     logic [9:0] sc, logic [1:0] st, logic [31:0] sq);
        tree_msg_t r;
        r = '{kind: k, dest: d, seg_addr: sa, seg_cost: sc, status: st, seq: sq, last: 1'b0};
        pending_msgs.push_back(r);
    endfunction

    function automatic void push_prune(logic [31:0] d, logic [1:0] st);
        push_msg((d == m_root) ? KIND_PRUNE_ROOT : KIND_PRUNE_PARENT, d, '0, '0, st, '0);
    endfunction

    // Applies one input item to the model and queues its results.
    function automatic void predict_tree(logic [2:0] act, logic [31:0] a, logic [9:0] v);
        int base, k, i;
        logic [1:0] st;
        logic [10:0] score;
        logic [9:0] cur, lc;
        logic [31:0] old;
        logic removed, is_root;
        base = pending_msgs.size();
        st = ST_OK;
        removed = 1'b0;
        is_root = (m_own == m_root);
        case (act)
            ACT_LOAD:
            begin
                if (lk_cnt >= MEMBERS) st = ST_FULL;
                else
                begin
                    lk_addr[lk_cnt] = a;
                    lk_cost[lk_cnt] = v;
                    lk_cnt++;
                    if (a == m_root && !m_root_seen)
                    begin
                        m_path = v;
                        m_root_seen = 1'b1;
                    end
                end
                push_msg(KIND_DONE, '0, '0, '0, st, '0);
            end
            ACT_TJOIN:
            begin
                k = -1;
                for (i = 0; i < tm_cnt; i++) if (k < 0 && tm_addr[i] == a) k = i;
                if (k >= 0) st = ST_PRESENT;
                else if (tm_cnt >= MEMBERS) st = ST_FULL;
                else tm_addr[tm_cnt++] = a;
                push_msg(KIND_JOIN_ROOT, m_root, '0, '0, st, '0);
            end
            ACT_RJOIN, ACT_CJOIN:
            begin
                if (act == ACT_RJOIN && !is_root)
                    push_msg(KIND_DONE, '0, '0, '0, ST_IGNORED, '0);
                else
                begin
                    k = -1;
                    for (i = 0; i < ch_cnt; i++) if (k < 0 && ch_addr[i] == a) k = i;
                    if (k >= 0) st = ST_PRESENT;
                    else if (ch_cnt >= MEMBERS) st = ST_FULL;
                    else
                    begin
                        lc = 10'd1;
                        if (act == ACT_RJOIN)
                        begin
                            k = -1;
                            for (i = 0; i < lk_cnt; i++) if (k < 0 && lk_addr[i] == a) k = i;
                            if (k >= 0) lc = lk_cost[k];
                        end
                        ch_addr[ch_cnt] = a;
                        ch_cost[ch_cnt] = lc;
                        ch_cnt++;
                    end
                    if (act == ACT_CJOIN)
                        push_msg(KIND_DONE, '0, '0, '0, st, '0);
                    else
                    begin
                        push_msg(KIND_SEGMENT, '0, m_own, '0, st, '0);
                        for (i = 0; i < ch_cnt; i++)
                            push_msg(KIND_SEGMENT, '0, ch_addr[i], ch_cost[i], st, '0);
                        for (i = 0; i < ch_cnt; i++)
                            push_msg(KIND_SEND_VECTOR, ch_addr[i], '0, '0, st, '0);
                    end
                end
            end
            ACT_SEG:
            begin
                if (a == m_own) push_msg(KIND_DONE, '0, '0, '0, ST_IGNORED, '0);
                else
                begin
                    lc = UNKNOWN_COST;
                    k = -1;
                    for (i = 0; i < lk_cnt; i++) if (k < 0 && lk_addr[i] == a) k = i;
                    if (k >= 0) lc = lk_cost[k];
                    score = {1'b0, v} + {1'b0, lc};
                    if (score > {1'b0, COST_MAX}) score = {1'b0, COST_MAX};
                    cur = is_root ? 10'd0 : m_path;
                    old = parent_now();
                    if (score > {1'b0, cur} || (score == {1'b0, cur} && old != a))
                        push_msg(KIND_DONE, '0, '0, '0, ST_IGNORED, '0);
                    else
                    begin
                        m_parent = a;
                        m_path = score[9:0];
                        if (old != a)
                        begin
                            n_reroutes++;
                            push_msg(KIND_JOIN_PARENT, a, '0, '0, ST_OK, '0);
                            push_prune(old, ST_OK);
                        end
                        else push_msg(KIND_DONE, '0, '0, '0, ST_OK, '0);
                    end
                end
            end
            ACT_TPRUNE, ACT_CPRUNE:
            begin
                i = 0;
                if (act == ACT_TPRUNE)
                begin
                    while (i < tm_cnt)
                        if (tm_addr[i] == a)
                        begin
                            tm_cnt--;
                            tm_addr[i] = tm_addr[tm_cnt];
                            removed = 1'b1;
                        end
                        else i++;
                end
                else
                begin
                    while (i < ch_cnt)
                        if (ch_addr[i] == a)
                        begin
                            ch_cnt--;
                            ch_addr[i] = ch_addr[ch_cnt];
                            ch_cost[i] = ch_cost[ch_cnt];
                            removed = 1'b1;
                        end
                        else i++;
                end
                st = removed ? ST_OK : ST_IGNORED;
                if (ch_cnt == 0 && tm_cnt == 0 && !is_root) push_prune(parent_now(), st);
                else push_msg(KIND_DONE, '0, '0, '0, st, '0);
            end
            default:
            begin
                m_dseq++;
                for (i = 0; i < tm_cnt; i++)
                    push_msg(KIND_FORWARD, tm_addr[i], '0, '0, ST_OK, m_dseq);
                for (i = 0; i < ch_cnt; i++)
                    if (ch_addr[i] != a)
                        push_msg(KIND_FORWARD, ch_addr[i], '0, '0, ST_OK, m_dseq);
                if (pending_msgs.size() == base)
                    push_msg(KIND_DONE, '0, '0, '0, ST_OK, m_dseq);
            end
        endcase
        pending_msgs[pending_msgs.size()-1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, n_results);
    endtask

    // Result checker, sampled on the rising edge.
    always @(posedge clk)
    begin
        tree_msg_t e;
        tree_msg_t g;
        if (rst_n && m_tvalid && m_tready)
        begin
            g = '{kind: m_tuser, dest: m_tdata[31:0], seg_addr: m_tdata[63:32],
                  seg_cost: m_tdata[73:64], status: m_tdata[75:74],
                  seq: m_tdata[107:76], last: m_tlast};
            n_results++;
            if (pending_msgs.size() == 0) report_mismatch("unexpected result", g.kind, 0);
            else
            begin
                e = pending_msgs.pop_front();
                if (g.kind != e.kind) report_mismatch("kind", g.kind, e.kind);
                if (g.dest != e.dest) report_mismatch("dest_addr", g.dest, e.dest);
                if (g.seg_addr != e.seg_addr) report_mismatch("seg_addr", g.seg_addr, e.seg_addr);
                if (g.seg_cost != e.seg_cost) report_mismatch("seg_cost", g.seg_cost, e.seg_cost);
                if (g.status != e.status) report_mismatch("status", g.status, e.status);
                if (g.seq != e.seq) report_mismatch("sequence_res", g.seq, e.seq);
                if (g.last != e.last) report_mismatch("last", g.last, e.last);
            end
        end
    end

    // Receiver stall pattern: ready most of the time, with random stalls drawn anew on each falling edge.
    always @(negedge clk)
    begin
        int phase;
        phase = $urandom_range(0, 15);
        if (!rst_n) m_tready <= 1'b0;
        else if (phase < 3) m_tready <= 1'b0;
        else if (phase < 5) m_tready <= ($urandom_range(0, 1) == 1);
        else m_tready <= 1'b1;
    end

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_OWN_ADDR) m_own = val;
        else m_root = val;
    endtask

    // Waits for the queue to drain and for the block to go quiet.
    task automatic drain_results();
        while (pending_msgs.size() != 0) @(posedge clk);
        repeat (4 * MEMBERS + 8) @(posedge clk);
    endtask

    // Sends one item; the caller lowers valid when a gap follows.
    task automatic send_item(logic [2:0] act, logic [31:0] a, logic [9:0] v);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {6'd0, v, a};
        do @(posedge clk); while (!s_tready);
        predict_tree(act, a, v);
        n_items++;
    endtask

    task automatic gap_cycles(int n);
        if (n > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] pick_addr(logic [31:0] peer);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 32'h0A00_0000 + $urandom_range(1, 6);
        else if (r < 6) return peer;
        else if (r < 7) return m_root;
        else if (r < 8) return m_own;
        else return $urandom;
    endfunction

    stim_row_t dir_rows[$];

    function automatic void add_row(logic [2:0] act, logic [31:0] a, logic [9:0] v,
                                    logic fx, logic [2:0] fk, logic [1:0] fs);
        stim_row_t r;
        r = '{action: act, addr: a, value: v, has_fixed: fx, fixed_kind: fk, fixed_status: fs};
        dir_rows.push_back(r);
    endfunction

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int i, b, burst;
        logic [2:0] act;
        logic [31:0] peer;

        m_own = '0; m_root = '0;
        lk_cnt = 0; tm_cnt = 0; ch_cnt = 0;
        m_path = UNKNOWN_COST; m_parent = '0; m_root_seen = 1'b0; m_dseq = '0;
        for (i = 0; i < MEMBERS; i++)
        begin
            lk_addr[i] = '0; lk_cost[i] = '0;
            tm_addr[i] = '0; ch_addr[i] = '0; ch_cost[i] = '0;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Phase 1: non-root node, parent through a link to the root.
        write_reg(CFG_OWN_ADDR, 32'hC0A8_0001);
        write_reg(CFG_ROOT_ADDR, 32'hFFFF_FFFF);

        // Directed table: fixed kind and status where the answer is obvious.
        add_row(ACT_DATA, 32'h0, 10'd0, 1'b1, KIND_DONE, ST_OK);
        add_row(ACT_RJOIN, 32'h1, 10'd0, 1'b1, KIND_DONE, ST_IGNORED);
        add_row(ACT_SEG, 32'hC0A8_0001, 10'd0, 1'b1, KIND_DONE, ST_IGNORED);
        add_row(ACT_TPRUNE, 32'h5, 10'd0, 1'b1, KIND_PRUNE_ROOT, ST_IGNORED);
        add_row(ACT_LOAD, 32'hFFFF_FFFF, 10'd1023, 1'b1, KIND_DONE, ST_OK);
        add_row(ACT_LOAD, 32'hFFFF_FFFF, 10'd5, 1'b1, KIND_DONE, ST_OK);
        add_row(ACT_LOAD, 32'h0A00_0002, 10'd0, 1'b1, KIND_DONE, ST_OK);
        add_row(ACT_SEG, 32'h0A00_0002, 10'd1023, 1'b0, KIND_DONE, ST_OK);
        add_row(ACT_SEG, 32'h0A00_0002, 10'd3, 1'b0, KIND_DONE, ST_OK);
        add_row(ACT_SEG, 32'h0A00_0002, 10'd2, 1'b0, KIND_DONE, ST_OK);
        add_row(ACT_SEG, 32'h0A00_0003, 10'd0, 1'b0, KIND_DONE, ST_OK);
        add_row(ACT_TJOIN, 32'h0, 10'd0, 1'b1, KIND_JOIN_ROOT, ST_OK);
        add_row(ACT_TJOIN, 32'h0, 10'd0, 1'b1, KIND_JOIN_ROOT, ST_PRESENT);
        add_row(ACT_CJOIN, 32'hFFFF_FFFF, 10'd0, 1'b1, KIND_DONE, ST_OK);
        add_row(ACT_CJOIN, 32'hFFFF_FFFF, 10'd0, 1'b1, KIND_DONE, ST_PRESENT);
        add_row(ACT_DATA, 32'hFFFF_FFFF, 10'd1023, 1'b0, KIND_DONE, ST_OK);
        add_row(ACT_DATA, 32'h1234_5678, 10'd0, 1'b0, KIND_DONE, ST_OK);
        add_row(ACT_TPRUNE, 32'h0, 10'd0, 1'b1, KIND_DONE, ST_OK);
        add_row(ACT_CPRUNE, 32'hFFFF_FFFF, 10'd0, 1'b0, KIND_DONE, ST_OK);
        // Fill the link table to overflow.
        for (i = 0; i < MEMBERS - 2; i++)
            add_row(ACT_LOAD, 32'h0A00_0010 + i, 10'(i * 70), 1'b0, KIND_DONE, ST_OK);
        add_row(ACT_LOAD, 32'h0A00_0099, 10'd7, 1'b1, KIND_DONE, ST_FULL);

        foreach (dir_rows[r])
        begin
            send_item(dir_rows[r].action, dir_rows[r].addr, dir_rows[r].value);
            if (dir_rows[r].has_fixed)
            begin
                if (pending_msgs[pending_msgs.size()-1].kind != dir_rows[r].fixed_kind)
                    report_mismatch("table kind", dir_rows[r].fixed_kind,
                                    pending_msgs[pending_msgs.size()-1].kind);
                if (pending_msgs[pending_msgs.size()-1].status != dir_rows[r].fixed_status)
                    report_mismatch("table status", dir_rows[r].fixed_status,
                                    pending_msgs[pending_msgs.size()-1].status);
            end
            gap_cycles($urandom_range(0, 2));
        end
        gap_cycles(1);
        drain_results();

        // Phase 2: root mode at address zero; fill the child table to full.
        write_reg(CFG_ROOT_ADDR, 32'h0);
        write_reg(CFG_OWN_ADDR, 32'h0);
        for (i = 0; i <= MEMBERS; i++)
            send_item(ACT_RJOIN, 32'h0B00_0000 + i, 10'd0);
        send_item(ACT_RJOIN, 32'h0B00_0003, 10'd0);
        send_item(ACT_DATA, 32'h0B00_0004, 10'd0);
        send_item(ACT_TJOIN, 32'h0B00_0004, 10'd0);
        send_item(ACT_DATA, 32'h0, 10'd0);
        gap_cycles(1);
        drain_results();
        for (i = 0; i <= MEMBERS; i++)
            send_item(ACT_CPRUNE, 32'h0B00_0000 + i, 10'd0);
        send_item(ACT_TPRUNE, 32'h0B00_0004, 10'd0);
        gap_cycles(1);
        drain_results();

        // Phase 3: random traffic in bursts, alternating node settings.
        for (b = 0; n_items < 100; b++)
        begin
            if (b % 6 == 0)
            begin
                gap_cycles(1);
                drain_results();
                write_reg(CFG_OWN_ADDR, (b % 12 == 0) ? $urandom : 32'h0A00_0001);
                write_reg(CFG_ROOT_ADDR, (b % 18 == 0) ? m_own : 32'h0A00_0005);
            end
            peer = 32'h0A00_0000 + $urandom_range(1, 6);
            burst = $urandom_range(1, 8);
            for (i = 0; i < burst; i++)
            begin
                // Mostly joins, segments and data, with prunes and loads mixed in.
                case ($urandom_range(0, 11))
                    0, 1:    act = ACT_SEG;
                    2, 3:    act = ACT_TJOIN;
                    4:       act = ACT_CJOIN;
                    5:       act = ACT_RJOIN;
                    6:       act = ACT_TPRUNE;
                    7:       act = ACT_CPRUNE;
                    8:       act = ACT_LOAD;
                    default: act = ACT_DATA;
                endcase
                send_item(act, pick_addr(peer),
                          ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40)));
            end
            if ($urandom_range(0, 3) == 0) gap_cycles($urandom_range(1, 60));
        end

        gap_cycles(1);
        while (pending_msgs.size() != 0) @(posedge clk);
        repeat (4 * MEMBERS + 8) @(posedge clk);

        $display("Run covered %0d items and %0d results, %0d parent switches.",
                 n_items, n_results, n_reroutes);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
